[sv/bqc_pkg.sv]
// Shared constants, codes and helpers of the cascaded biquad filter.
package bqc_pkg;

    // Block dimensions.
    localparam int SECTIONS      = 4;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEFF_BITS    = 32;
    localparam int HIST_BITS     = 40;
    localparam int COEFS_PER_SEC = 5;
    localparam int COEF_DEPTH    = SECTIONS * COEFS_PER_SEC;
    localparam int COEF_AW       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int SEC_W         = 2;
    localparam int SEL_W         = 3;
    localparam int OP_W          = 2;
    localparam int CFG_W         = 3;

    // Fixed-point scaling of the products.
    localparam int COEF_FRAC = COEFF_BITS - 4;
    localparam int SPLIT     = 20;
    localparam int MB_W      = SPLIT + 1;
    localparam int PHI_W     = COEFF_BITS + HIST_BITS - SPLIT;
    localparam int PROD_W    = COEFF_BITS + MB_W;
    localparam int FULL_W    = COEFF_BITS + HIST_BITS;
    localparam int MUL_W     = FULL_W - COEF_FRAC;
    localparam int ACC_BITS  = MUL_W + 1;

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Coefficient selection codes.
    localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
    localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
    localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
    localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
    localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

    // Saturate an accumulator value to the history range.
    function automatic logic signed [HIST_BITS-1:0] sat_hist(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-HIST_BITS:0] top;
        top = v[ACC_BITS-1:HIST_BITS-1];
        if ((&top) || !(|top)) begin
            return v[HIST_BITS-1:0];
        end else if (v[ACC_BITS-1]) begin
            return {1'b1, {(HIST_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(HIST_BITS-1){1'b1}}};
        end
    endfunction

endpackage

[sv/biquad_cascade_filter.sv]
// Cascaded direct-form-II biquad filter with one shared multiplier.
//
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_ready      i_op, i_sample_in, i_section_index,
//                                             i_coeff_select, i_coeff_value
// output    out        o_valid / i_ready      o_sample_out, o_status
// config    in         i_cfg_we               i_cfg_data (active section count)
//
// A filter beat holds the block until all n active sections are worked, n being the active section count.
// Each section needs five products, and each product is worked in three steps on the
// single 32x21 multiplier: two partial products and a rounding accumulate.
// Coefficient writes, clears and unused codes leave the block ready for the next beat and give no result.
// A sample that arrives while the fault is latched skips the sections and goes straight to the final state.
// Reset is synchronous and clears coefficients, histories, the fault and the last output.
// A finished result waits in the output register; a new beat is taken meanwhile.
// The sequencer holds in its final state while that register is full and stalled.
module biquad_cascade_filter
    import bqc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [OP_W-1:0]               i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [SEC_W-1:0]              i_section_index,
    input  logic [SEL_W-1:0]              i_coeff_select,
    input  logic signed [COEFF_BITS-1:0]  i_coeff_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HI   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_W0   = 3'd4;
    localparam logic [2:0] S_Y    = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Product terms of one section, in the order they are worked.
    localparam logic [2:0] T_A1 = 3'd0;
    localparam logic [2:0] T_A2 = 3'd1;
    localparam logic [2:0] T_B0 = 3'd2;
    localparam logic [2:0] T_B1 = 3'd3;
    localparam logic [2:0] T_B2 = 3'd4;

    localparam logic [FULL_W-1:0] ROUND = FULL_W'(1) << (COEF_FRAC - 1);

    logic [2:0]                        r_state;
    logic [SEC_W-1:0]                  r_sec;
    logic [2:0]                        r_term;
    logic                              r_skip;
    logic [CFG_W-1:0]                  r_active;
    logic signed [COEFF_BITS-1:0]      r_coef [COEF_DEPTH];
    logic signed [HIST_BITS-1:0]       r_h1 [SECTIONS];
    logic signed [HIST_BITS-1:0]       r_h2 [SECTIONS];
    logic signed [SAMPLE_BITS-1:0]     r_last;
    logic                              r_fault;
    logic                              r_o_valid;
    logic signed [SAMPLE_BITS-1:0]     r_o_sample;
    logic                              r_o_status;
    logic signed [PHI_W-1:0]           r_p;
    logic signed [PROD_W-1:0]          r_q;
    logic signed [ACC_BITS-1:0]        r_acc;
    logic signed [HIST_BITS-1:0]       r_w0;

    logic [SEC_W-1:0]                  w_last_sec;
    logic [SEL_W-1:0]                  w_sel;
    logic [COEF_AW-1:0]                w_caddr;
    logic [COEF_AW-1:0]                w_waddr;
    logic                              w_wr_ok;
    logic signed [COEFF_BITS-1:0]      w_coef;
    logic signed [HIST_BITS-1:0]       w_h;
    logic signed [MB_W-1:0]            w_mb;
    logic signed [PROD_W-1:0]          w_prod;
    logic signed [FULL_W-1:0]          w_full;
    logic signed [ACC_BITS-1:0]        w_term;
    logic signed [HIST_BITS-1:0]       w_sat;
    logic                              w_in_beat;
    logic                              w_out_free;
    logic                              w_fin_go;
    logic                              w_ovf;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    // Effective last section: zero acts as one, large counts clamp.
    always_comb begin
        if (r_active == '0) begin
            w_last_sec = '0;
        end else if (r_active > CFG_W'(SECTIONS)) begin
            w_last_sec = SEC_W'(SECTIONS - 1);
        end else begin
            w_last_sec = SEC_W'(r_active - CFG_W'(1));
        end
    end

    // Coefficient and history operand for the current term.
    always_comb begin
        case (r_term)
            T_A1: begin
                w_sel = COEF_A1;
                w_h   = r_h1[r_sec];
            end
            T_A2: begin
                w_sel = COEF_A2;
                w_h   = r_h2[r_sec];
            end
            T_B0: begin
                w_sel = COEF_B0;
                w_h   = r_w0;
            end
            T_B1: begin
                w_sel = COEF_B1;
                w_h   = r_h1[r_sec];
            end
            T_B2: begin
                w_sel = COEF_B2;
                w_h   = r_h2[r_sec];
            end
            default: begin
                w_sel = COEF_B0;
                w_h   = '0;
            end
        endcase
    end

    assign w_caddr = COEF_AW'(r_sec) * COEF_AW'(COEFS_PER_SEC) + COEF_AW'(w_sel);
    assign w_coef  = r_coef[w_caddr];

    // Coefficient write address and range check.
    assign w_waddr = COEF_AW'(i_section_index) * COEF_AW'(COEFS_PER_SEC)
                   + COEF_AW'(i_coeff_select);
    assign w_wr_ok = (32'(i_section_index) < SECTIONS)
                  && (32'(i_coeff_select) < COEFS_PER_SEC);

    // Shared multiplier: upper history bits in the first pass, lower bits next.
    assign w_mb   = (r_state == S_HI) ? {w_h[HIST_BITS-1], w_h[HIST_BITS-1:SPLIT]}
                                      : {1'b0, w_h[SPLIT-1:0]};
    assign w_prod = w_coef * w_mb;

    // Recombine the partial products, round half up and drop the fraction.
    assign w_full = {r_p, {SPLIT{1'b0}}} + {{(FULL_W-PROD_W){r_q[PROD_W-1]}}, r_q} + ROUND;
    assign w_term = {w_full[FULL_W-1], w_full[FULL_W-1:COEF_FRAC]};

    assign w_sat = sat_hist(r_acc);
    assign w_ovf = !((&r_acc[HIST_BITS-1:SAMPLE_BITS-1]) || !(|r_acc[HIST_BITS-1:SAMPLE_BITS-1]));

    // Sequencer, filter state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sec     <= '0;
            r_term    <= T_A1;
            r_skip    <= 1'b0;
            r_active  <= CFG_W'(1);
            r_last    <= '0;
            r_fault   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < COEF_DEPTH; i++) begin
                r_coef[i] <= '0;
            end
            for (int i = 0; i < SECTIONS; i++) begin
                r_h1[i] <= '0;
                r_h2[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            // The output register fills when a result is done and empties on its beat.
            if (w_fin_go) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        case (i_op)
                            OP_FILTER: begin
                                r_sec  <= '0;
                                r_term <= T_A1;
                                r_skip <= r_fault;
                                r_state <= r_fault ? S_FIN : S_HI;
                            end
                            OP_WRITE: begin
                                if (w_wr_ok) begin
                                    r_coef[w_waddr] <= i_coeff_value;
                                end
                            end
                            OP_CLEAR: begin
                                for (int i = 0; i < SECTIONS; i++) begin
                                    r_h1[i] <= '0;
                                    r_h2[i] <= '0;
                                end
                                r_last  <= '0;
                                r_fault <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_HI: begin
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_term == T_A2) begin
                        r_state <= S_W0;
                    end else if (r_term == T_B2) begin
                        r_state <= S_Y;
                    end else begin
                        r_term  <= r_term + 3'd1;
                        r_state <= S_HI;
                    end
                end
                S_W0: begin
                    r_term  <= T_B0;
                    r_state <= S_HI;
                end
                S_Y: begin
                    r_h2[r_sec] <= r_h1[r_sec];
                    r_h1[r_sec] <= r_w0;
                    r_term      <= T_A1;
                    if (r_sec == w_last_sec) begin
                        r_state <= S_FIN;
                    end else begin
                        r_sec   <= r_sec + SEC_W'(1);
                        r_state <= S_HI;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        if (!r_skip && !w_ovf) begin
                            r_last <= r_acc[SAMPLE_BITS-1:0];
                        end else if (!r_skip) begin
                            r_fault <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_acc <= {{(ACC_BITS-SAMPLE_BITS){i_sample_in[SAMPLE_BITS-1]}}, i_sample_in};
            end
            S_HI: begin
                r_p <= w_prod[PHI_W-1:0];
            end
            S_LO: begin
                r_q <= w_prod;
            end
            S_ACC: begin
                if (r_term == T_A1 || r_term == T_A2) begin
                    r_acc <= r_acc - w_term;
                end else begin
                    r_acc <= r_acc + w_term;
                end
            end
            S_W0: begin
                r_w0  <= w_sat;
                r_acc <= '0;
            end
            S_Y: begin
                r_acc <= {{(ACC_BITS-HIST_BITS){w_sat[HIST_BITS-1]}}, w_sat};
            end
            S_FIN: begin
                if (w_out_free) begin
                    if (!r_skip && !w_ovf) begin
                        r_o_sample <= r_acc[SAMPLE_BITS-1:0];
                        r_o_status <= 1'b0;
                    end else begin
                        r_o_sample <= r_last;
                        r_o_status <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_sample_out = r_o_sample;
    assign o_status     = r_o_status;

endmodule

[sv/bqc_checker.sv]
// Port-level checker of the cascaded biquad filter and its bind.
module bqc_checker
    import bqc_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [OP_W-1:0]               i_op,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic                          o_status
);

    logic [1:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;
    logic       w_in_filter;

    assign w_in_beat   = i_valid && o_ready;
    assign w_out_beat  = o_valid && i_ready;
    assign w_in_filter = w_in_beat && (i_op == OP_FILTER);

    // Count filter beats whose result beat is still owed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_filter && !w_out_beat) begin
            r_pend <= r_pend + 2'd1;
        end else if (!w_in_filter && w_out_beat) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out) && $stable(o_status))
        else $error("result beat changed while stalled");

    // A filter beat occupies the block for at least the next cycle.
    a_busy_after_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_filter |=> !o_ready)
        else $error("block ready right after a filter beat");

    // Writes, clears and unused codes leave the block ready.
    a_ready_after_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && (i_op != OP_FILTER) |=> o_ready)
        else $error("block busy after a beat without result");

    // Every result beat answers an earlier filter beat.
    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> (r_pend != 2'd0))
        else $error("result beat without a filter beat");

    // At most one result waits while another sample is in work.
    a_no_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd2) |-> !o_ready)
        else $error("block ready with two results owed");

endmodule

bind biquad_cascade_filter bqc_checker u_bqc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out),
    .o_status     (o_status)
);

[bench/biquad_cascade_filter_tb.sv]
// Self-checking testbench for the cascaded biquad filter with a built-in fixed-point predictor.
module biquad_cascade_filter_tb;
    import bqc_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
    localparam logic [SEL_W-1:0] SEL_UNUSED = 3'd7;

    // Fixed-point constants for Q3.28 coefficients.
    localparam logic signed [COEFF_BITS-1:0] COEF_ONE  = 32'sh1000_0000;
    localparam logic signed [COEFF_BITS-1:0] COEF_HALF = 32'sh0800_0000;
    localparam logic signed [COEFF_BITS-1:0] COEF_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COEFF_BITS-1:0] COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [SAMPLE_BITS-1:0] PCM_MAX  = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_BITS-1:0] PCM_MIN  = 24'sh80_0000;

    // Accumulator range and rounding term of the predictor.
    localparam int ACC_W = HIST_BITS + 8;
    localparam logic signed [ACC_W-1:0] HIST_HI = (48'sd1 <<< (HIST_BITS - 1)) - 48'sd1;
    localparam logic signed [ACC_W-1:0] HIST_LO = -(48'sd1 <<< (HIST_BITS - 1));
    localparam logic signed [FULL_W:0]  ROUND_HALF = 1 <<< (COEF_FRAC - 1);

    // Run control.
    localparam int RANDOM_BEATS   = 1400;
    localparam int PHASES         = 8;
    localparam int DRAIN_CYCLES   = 17 * SECTIONS + 12;
    localparam int WATCHDOG_LIMIT = 3000;

    // Section counts used by the random phases, out-of-range values included.
    int cfg_plan [PHASES] = '{4, 0, 7, 2, 3, 5, 1, 4};

    typedef struct {
        logic [OP_W-1:0]               op;
        logic signed [SAMPLE_BITS-1:0] din;
        logic [SEC_W-1:0]              sec;
        logic [SEL_W-1:0]              sel;
        logic signed [COEFF_BITS-1:0]  coeff;
    } filt_beat_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] dout;
        logic                          status;
    } filt_out_t;

    // Clock, reset and block ports.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [OP_W-1:0]               i_op = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic [SEC_W-1:0]              i_section_index = '0;
    logic [SEL_W-1:0]              i_coeff_select = '0;
    logic signed [COEFF_BITS-1:0]  i_coeff_value = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_status;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_W-1:0]              i_cfg_data = '0;

    // Predictor state.
    logic signed [COEFF_BITS-1:0]  coef_mem [COEF_DEPTH];
    logic signed [HIST_BITS-1:0]   hist_w1 [SECTIONS];
    logic signed [HIST_BITS-1:0]   hist_w2 [SECTIONS];
    logic signed [SAMPLE_BITS-1:0] held_out;
    logic                          fault_flag;
    logic [CFG_W-1:0]              sections_cfg;

    // Stimulus and scoreboard storage.
    filt_beat_t pending_beats [$];
    filt_out_t  expected_outputs [$];
    filt_beat_t cur_beat;
    int         send_wait = 0;
    int         recv_wait = 0;
    bit         gapless = 1'b0;
    bit         stall_free = 1'b0;
    int         quiet_cycles = 0;
    int         mismatches = 0;
    int         outputs_checked = 0;
    int         fault_outputs = 0;
    int         n_filter = 0;
    int         n_write = 0;
    int         n_clear = 0;
    int         n_ignored = 0;
    int         n_settings = 1;

    biquad_cascade_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_sample_in     (i_sample_in),
        .i_section_index (i_section_index),
        .i_coeff_select  (i_coeff_select),
        .i_coeff_value   (i_coeff_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_out    (o_sample_out),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Rounded Q3.28 product: add half an LSB, then floor shift.
    function automatic logic signed [HIST_BITS+4:0] coef_times(
        input logic signed [COEFF_BITS-1:0] c,
        input logic signed [HIST_BITS-1:0]  h
    );
        logic signed [FULL_W:0] prod;
        prod = c * h;
        prod = prod + ROUND_HALF;
        return (HIST_BITS+5)'(prod >>> COEF_FRAC);
    endfunction

    function automatic logic signed [HIST_BITS-1:0] clamp_hist(input logic signed [ACC_W-1:0] v);
        if (v > HIST_HI) begin
            return HIST_HI[HIST_BITS-1:0];
        end else if (v < HIST_LO) begin
            return HIST_LO[HIST_BITS-1:0];
        end
        return v[HIST_BITS-1:0];
    endfunction

    // One direct-form-II section; shifts its history words.
    function automatic logic signed [HIST_BITS-1:0] run_biquad(
        input int s,
        input logic signed [HIST_BITS-1:0] x
    );
        logic signed [ACC_W-1:0]     acc;
        logic signed [HIST_BITS-1:0] w0;
        int                          base;
        base = s * COEFS_PER_SEC;
        acc = x - coef_times(coef_mem[base + COEF_A1], hist_w1[s])
                - coef_times(coef_mem[base + COEF_A2], hist_w2[s]);
        w0 = clamp_hist(acc);
        acc = coef_times(coef_mem[base + COEF_B0], w0)
            + coef_times(coef_mem[base + COEF_B1], hist_w1[s])
            + coef_times(coef_mem[base + COEF_B2], hist_w2[s]);
        hist_w2[s] = hist_w1[s];
        hist_w1[s] = w0;
        return clamp_hist(acc);
    endfunction

    function automatic void clear_history();
        for (int s = 0; s < SECTIONS; s++) begin
            hist_w1[s] = '0;
            hist_w2[s] = '0;
        end
        held_out = '0;
        fault_flag = 1'b0;
    endfunction

    function automatic void model_reset();
        for (int k = 0; k < COEF_DEPTH; k++) begin
            coef_mem[k] = '0;
        end
        clear_history();
        sections_cfg = 3'd1;
    endfunction

    // Update the predictor with one accepted beat and queue any output it causes.
    function automatic void apply_beat(input filt_beat_t b);
        logic signed [HIST_BITS-1:0] v;
        filt_out_t                   r;
        int                          n;
        case (b.op)
            OP_WRITE: begin
                if (int'(b.sec) < SECTIONS && b.sel <= COEF_A2) begin
                    coef_mem[int'(b.sec) * COEFS_PER_SEC + int'(b.sel)] = b.coeff;
                    n_write++;
                end else begin
                    n_ignored++;
                end
            end
            OP_CLEAR: begin
                clear_history();
                n_clear++;
            end
            OP_FILTER: begin
                n_filter++;
                if (!fault_flag) begin
                    n = int'(sections_cfg);
                    if (n < 1) n = 1;
                    if (n > SECTIONS) n = SECTIONS;
                    v = HIST_BITS'(b.din);
                    for (int s = 0; s < n; s++) begin
                        v = run_biquad(s, v);
                    end
                    // The top bits must all match the sign bit of the output width.
                    if ((&v[HIST_BITS-1:SAMPLE_BITS-1]) || !(|v[HIST_BITS-1:SAMPLE_BITS-1])) begin
                        held_out = v[SAMPLE_BITS-1:0];
                    end else begin
                        fault_flag = 1'b1;
                    end
                end
                r.dout = held_out;
                r.status = fault_flag;
                expected_outputs.push_back(r);
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    // Stimulus builders.
    function automatic void push_beat(
        input logic [OP_W-1:0]               op,
        input logic signed [SAMPLE_BITS-1:0] din,
        input logic [SEC_W-1:0]              sec,
        input logic [SEL_W-1:0]              sel,
        input logic signed [COEFF_BITS-1:0]  coeff
    );
        filt_beat_t b;
        b.op = op;
        b.din = din;
        b.sec = sec;
        b.sel = sel;
        b.coeff = coeff;
        pending_beats.push_back(b);
    endfunction

    function automatic void push_filter(input logic signed [SAMPLE_BITS-1:0] din);
        push_beat(OP_FILTER, din, SEC_W'($urandom), SEL_W'($urandom), $urandom);
    endfunction

    function automatic void push_write(
        input logic [SEC_W-1:0]              sec,
        input logic [SEL_W-1:0]              sel,
        input logic signed [COEFF_BITS-1:0]  coeff
    );
        push_beat(OP_WRITE, SAMPLE_BITS'($urandom), sec, sel, coeff);
    endfunction

    function automatic void push_clear();
        push_beat(OP_CLEAR, SAMPLE_BITS'($urandom), SEC_W'($urandom), SEL_W'($urandom), $urandom);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return PCM_MAX;
            1: return PCM_MIN;
            2, 3, 4: return SAMPLE_BITS'($urandom);
            default: return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic signed [COEFF_BITS-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COEF_MAX;
            2: return COEF_MIN;
            3: return COEF_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Coefficient of magnitude up to lim/256 with random fraction bits below that step.
    function automatic logic signed [COEFF_BITS-1:0] ranged_coeff(input int lim);
        int k;
        k = int'($urandom_range(0, 2 * lim)) - lim;
        return COEFF_BITS'((k <<< 20) + int'($urandom_range(0, 20'hFFFFF)));
    endfunction

    // Program one section with a stable pole pair and modest zeros.
    function automatic void queue_stable_section(input int s);
        int a2_lim;
        int a1_lim;
        int k2;
        int gain;
        a2_lim = 230;
        k2 = int'($urandom_range(0, 2 * a2_lim)) - a2_lim;
        a1_lim = ((256 + k2) * 9) / 10;
        gain = ($urandom_range(0, 9) == 0) ? 512 : 128;
        push_write(SEC_W'(s), COEF_B0, ranged_coeff(gain));
        push_write(SEC_W'(s), COEF_B1, ranged_coeff(gain));
        push_write(SEC_W'(s), COEF_B2, ranged_coeff(gain));
        push_write(SEC_W'(s), COEF_A1, ranged_coeff(a1_lim));
        push_write(SEC_W'(s), COEF_A2, COEFF_BITS'(k2 <<< 20));
    endfunction

    // Random traffic: mostly program-clear-stream sequences, some raw noise.
    function automatic void queue_traffic(input int beats);
        int made;
        int roll;
        int run;
        int op;
        int sel;
        made = 0;
        while (made < beats) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                for (int s = 0; s < SECTIONS; s++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        queue_stable_section(s);
                        made += COEFS_PER_SEC;
                    end
                end
                push_clear();
                run = $urandom_range(4, 24);
                repeat (run) push_filter(pick_sample());
                made += run + 1;
            end else if (roll < 85) begin
                run = $urandom_range(1, 6);
                repeat (run) begin
                    push_write(SEC_W'($urandom), SEL_W'($urandom_range(0, 4)), pick_coeff());
                end
                made += run;
                if ($urandom_range(0, 1) == 1) begin
                    push_clear();
                    made++;
                end
                run = $urandom_range(1, 8);
                repeat (run) push_filter(pick_sample());
                made += run;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    op = $urandom_range(0, 3);
                    sel = $urandom_range(0, 7);
                    push_beat(OP_W'(op), pick_sample(), SEC_W'($urandom), SEL_W'(sel),
                              pick_coeff());
                    if (OP_W'(op) != OP_UNUSED && !(OP_W'(op) == OP_WRITE && SEL_W'(sel) > COEF_A2))
                        made++;
                end
            end
        end
    endfunction

    // Directed opening: extremes, rounding, every operation, fault and clear.
    function automatic void queue_directed();
        push_filter(PCM_MAX);
        push_filter(PCM_MIN);
        push_write(2'd0, SEL_UNUSED, COEF_MAX);
        push_beat(OP_UNUSED, PCM_MAX, 2'd3, SEL_UNUSED, COEF_MIN);
        push_write(2'd0, COEF_B0, COEF_ONE);
        push_write(2'd3, COEF_B0, COEF_ONE);
        push_filter(PCM_MAX);
        push_filter(PCM_MIN);
        // Half-LSB products round toward plus infinity.
        push_write(2'd0, COEF_B0, COEF_HALF);
        push_filter(24'sd1);
        push_filter(-24'sd1);
        // Large feedback with no zeros grows the history without a fault.
        push_write(2'd0, COEF_B0, '0);
        push_write(2'd0, COEF_A1, COEF_MIN);
        repeat (5) push_filter(PCM_MAX);
        // Output overflow latches the fault; later samples hold the last good value.
        push_clear();
        push_write(2'd0, COEF_A1, '0);
        push_write(2'd0, COEF_B0, COEF_MAX);
        push_filter(24'sd1000);
        push_filter(PCM_MAX);
        push_filter(24'sd5);
        push_clear();
        push_write(2'd0, COEF_B0, COEF_MIN);
        push_filter(PCM_MIN);
        push_clear();
    endfunction

    // Driver: present one beat at a time, with a random gap drawn per beat unless gapless is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_beat(cur_beat);
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    i_op <= cur_beat.op;
                    i_sample_in <= cur_beat.din;
                    i_section_index <= cur_beat.sec;
                    i_coeff_select <= cur_beat.sel;
                    i_coeff_value <= cur_beat.coeff;
                    i_valid <= 1'b1;
                    send_wait = gapless ? 0 : $urandom_range(0, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall each output beat a random number of cycles, then compare.
    always @(posedge i_clk) begin : out_monitor
        filt_out_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                outputs_checked++;
                if (o_status) fault_outputs++;
                if (expected_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected output %0d status %0b", $time,
                                 o_sample_out, o_status);
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_sample_out !== want.dout || o_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d status %0b, got %0d status %0b", $time,
                                     want.dout, want.status, o_sample_out, o_status);
                    end
                end
                recv_wait = stall_free ? 0 : $urandom_range(0, 4);
            end else if (o_valid && recv_wait > 0) begin
                recv_wait--;
            end
            i_ready <= (recv_wait == 0);
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold off until every queued beat is taken and every output has come back.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_beats.size() != 0 || i_valid || expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_section_count(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sections_cfg = value;
        n_settings++;
    endtask

    // Sequence: reset, directed part, then random phases at several section counts.
    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        wait_idle();
        for (int p = 0; p < PHASES; p++) begin
            write_section_count(CFG_W'(cfg_plan[p]));
            @(negedge i_clk);
            gapless = (p == 3);
            stall_free = (p == 3 || p == 6);
            queue_traffic(RANDOM_BEATS / PHASES);
            wait_idle();
        end
        $display("Covered %0d samples, %0d coefficient writes, %0d clears, %0d ignored beats",
                 n_filter, n_write, n_clear, n_ignored);
        $display("over %0d section-count settings; %0d outputs checked, %0d with fault set.",
                 n_settings, outputs_checked, fault_outputs);
        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d outputs missing", mismatches, expected_outputs.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
